### rtl/decimal_trailing_zero_strip_assert.svh
// assertion macros for the decimal trailing zero strip checker
// expects clk and rst_n in the scope of every use
`ifndef DECIMAL_TRAILING_ZERO_STRIP_ASSERT_SVH
`define DECIMAL_TRAILING_ZERO_STRIP_ASSERT_SVH

// same-cycle implication
`define DTZS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTZS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dtzs_pkg.sv
// shared types and constants of the decimal trailing zero strip
// no dependencies
package dtzs_pkg;

    localparam int CLASS_W     = 2;
    localparam int ERR_W       = 2;
    localparam int SCALE_W     = 14;
    localparam int HI_W        = 49;
    localparam int LO_W        = 64;
    localparam int COEF_W      = HI_W + LO_W;

    localparam int LIMB_W      = 29;
    localparam int NUM_LIMBS   = 4;
    localparam int PAD_W       = LIMB_W * NUM_LIMBS;
    localparam int LIMB_IDX_W  = $clog2(NUM_LIMBS);
    localparam int REM_W       = 4;
    localparam int DIV_IN_W    = REM_W + LIMB_W;
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = DIV_IN_W + RECIP_W;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'd3435973837;

    localparam int STEP_LIMIT  = 40;
    localparam int STEP_W      = $clog2(STEP_LIMIT + 1);

    typedef enum logic [CLASS_W-1:0] {
        CLS_FINITE = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_INF    = 2'd2,
        CLS_NAN    = 2'd3
    } class_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK  = 2'd0,
        ERR_NAN = 2'd1,
        ERR_INF = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_en;
        logic commit;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic need_strip;
        logic last_limb;
        logic rem_zero;
        logic more;
    } status_t;

endpackage

### rtl/decimal_trailing_zero_strip.sv
// top level of the decimal trailing zero strip
// depends on dtzs_pkg, dtzs_ctrl and dtzs_datapath
//
// usage
// - input channel in_valid/in_ready carries one unpacked decimal value per
//   transfer; output channel out_valid/out_ready returns exactly one result
// - a transfer is taken only while the unit is idle; one value is worked at a time
// - no trial division is made when the value is not finite, the coefficient is
//   zero or the scale is not negative; otherwise each removed digit is one
//   trial, and a trial that fails adds one more; at most 34 digits are removed
// - every trial divides the 113-bit coefficient by ten in four 29-bit limbs,
//   one limb per cycle through a single 33x32 reciprocal multiplier
// - a new value is taken only after the last result has gone to the output register
// - the result sits in an output register, so the next value can be taken
//   while a result waits; a stalled receiver only holds the unit at its
//   hand-off point when the output register is still full
// - reset empties the output register and returns the unit to idle
module decimal_trailing_zero_strip (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dtzs_pkg::CLASS_W-1:0]         value_class,
    input  logic                                 sign_in,
    input  logic signed [dtzs_pkg::SCALE_W-1:0]  scale_in,
    input  logic [dtzs_pkg::HI_W-1:0]            coef_hi_in,
    input  logic [dtzs_pkg::LO_W-1:0]            coef_lo_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dtzs_pkg::ERR_W-1:0]           error_code,
    output logic                                 sign_out,
    output logic signed [dtzs_pkg::SCALE_W-1:0]  scale_out,
    output logic [dtzs_pkg::HI_W-1:0]            coef_hi_out,
    output logic [dtzs_pkg::LO_W-1:0]            coef_lo_out
);
    import dtzs_pkg::*;

    cmd_t    cmd;
    status_t status;

    dtzs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dtzs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value_class (value_class),
        .sign_in     (sign_in),
        .scale_in    (scale_in),
        .coef_hi_in  (coef_hi_in),
        .coef_lo_in  (coef_lo_in),
        .error_code  (error_code),
        .sign_out    (sign_out),
        .scale_out   (scale_out),
        .coef_hi_out (coef_hi_out),
        .coef_lo_out (coef_lo_out)
    );

endmodule

### rtl/dtzs_datapath.sv
// datapath: operand registers, limb-serial divide by ten, result register
// depends on dtzs_pkg
module dtzs_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dtzs_pkg::cmd_t                       cmd,
    output dtzs_pkg::status_t                    status,
    input  logic [dtzs_pkg::CLASS_W-1:0]         value_class,
    input  logic                                 sign_in,
    input  logic signed [dtzs_pkg::SCALE_W-1:0]  scale_in,
    input  logic [dtzs_pkg::HI_W-1:0]            coef_hi_in,
    input  logic [dtzs_pkg::LO_W-1:0]            coef_lo_in,
    output logic [dtzs_pkg::ERR_W-1:0]           error_code,
    output logic                                 sign_out,
    output logic signed [dtzs_pkg::SCALE_W-1:0]  scale_out,
    output logic [dtzs_pkg::HI_W-1:0]            coef_hi_out,
    output logic [dtzs_pkg::LO_W-1:0]            coef_lo_out
);
    import dtzs_pkg::*;

    class_t                     class_reg;
    logic                       sign_reg;
    logic signed [SCALE_W-1:0]  scale_reg;
    logic [COEF_W-1:0]          coef_reg;
    logic [PAD_W-1:0]           work_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [LIMB_IDX_W-1:0]      limb_idx_reg;
    logic [STEP_W-1:0]          step_cnt_reg;

    err_t                       err_out_reg;
    logic                       sign_out_reg;
    logic signed [SCALE_W-1:0]  scale_out_reg;
    logic [COEF_W-1:0]          coef_out_reg;

    logic [COEF_W-1:0]          coef_in;
    logic                       in_zero_fin;
    logic [DIV_IN_W-1:0]        div_x;
    logic [PROD_W-1:0]          div_prod;
    logic [LIMB_W-1:0]          div_q;
    logic [DIV_IN_W-1:0]        div_q10;
    logic [DIV_IN_W-1:0]        div_r_full;
    logic [REM_W-1:0]           div_r;
    logic [PAD_W-1:0]           work_shift;
    logic signed [SCALE_W-1:0]  scale_plus;
    err_t                       err_sel;

    always_comb
    begin
        coef_in     = {coef_hi_in, coef_lo_in};
        in_zero_fin = (class_t'(value_class) == CLS_FINITE) && (coef_in == '0);

        // one 29-bit limb per cycle, most significant first
        div_x      = {rem_reg, work_reg[PAD_W-1 -: LIMB_W]};
        div_prod   = PROD_W'(div_x) * PROD_W'(RECIP_TEN);
        div_q      = div_prod[RECIP_SHIFT +: LIMB_W];
        div_q10    = DIV_IN_W'({div_q, 3'b000}) + DIV_IN_W'({div_q, 1'b0});
        div_r_full = div_x - div_q10;
        div_r      = div_r_full[REM_W-1:0];
        work_shift = {work_reg[PAD_W-LIMB_W-1:0], div_q};

        scale_plus = scale_reg + SCALE_W'(1);

        status.need_strip = (class_reg == CLS_FINITE) && (coef_reg != '0)
                            && scale_reg[SCALE_W-1]
                            && (step_cnt_reg < STEP_W'(STEP_LIMIT));
        status.last_limb  = (limb_idx_reg == LIMB_IDX_W'(NUM_LIMBS - 1));
        status.rem_zero   = (div_r == '0);
        status.more       = scale_plus[SCALE_W-1]
                            && (step_cnt_reg < STEP_W'(STEP_LIMIT - 1));

        unique case (class_reg)
            CLS_NAN: err_sel = ERR_NAN;
            CLS_INF: err_sel = ERR_INF;
            default: err_sel = ERR_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            limb_idx_reg <= '0;
            step_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            rem_reg      <= '0;
            limb_idx_reg <= '0;
            step_cnt_reg <= '0;
        end
        else if (cmd.div_en)
        begin
            rem_reg      <= status.last_limb ? '0 : div_r;
            limb_idx_reg <= limb_idx_reg + LIMB_IDX_W'(1);
            if (cmd.commit)
            begin
                step_cnt_reg <= step_cnt_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            class_reg <= class_t'(value_class);
            sign_reg  <= in_zero_fin ? 1'b0 : sign_in;
            scale_reg <= in_zero_fin ? '0 : scale_in;
            coef_reg  <= coef_in;
            work_reg  <= PAD_W'(coef_in);
        end
        else if (cmd.div_en)
        begin
            work_reg <= work_shift;
            if (cmd.commit)
            begin
                coef_reg  <= work_shift[COEF_W-1:0];
                scale_reg <= scale_plus;
            end
        end

        if (cmd.publish)
        begin
            err_out_reg   <= err_sel;
            sign_out_reg  <= sign_reg;
            scale_out_reg <= scale_reg;
            coef_out_reg  <= coef_reg;
        end
    end

    assign error_code  = err_out_reg;
    assign sign_out    = sign_out_reg;
    assign scale_out   = scale_out_reg;
    assign coef_hi_out = coef_out_reg[COEF_W-1:LO_W];
    assign coef_lo_out = coef_out_reg[LO_W-1:0];

endmodule

### rtl/dtzs_ctrl.sv
// controller: sequences load, divide passes and hand-off to the output register
// depends on dtzs_pkg
module dtzs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dtzs_pkg::status_t  status,
    output dtzs_pkg::cmd_t     cmd
);
    import dtzs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.need_strip ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (status.last_limb)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.commit = 1'b1;
                        state_next = status.more ? ST_DIV : ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/dtzs_checker.sv
// port-level checker for the decimal trailing zero strip, bound to the top level
// depends on dtzs_pkg and decimal_trailing_zero_strip_assert.svh
`include "decimal_trailing_zero_strip_assert.svh"

module dtzs_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [dtzs_pkg::CLASS_W-1:0]         value_class,
    input  logic                                 sign_in,
    input  logic signed [dtzs_pkg::SCALE_W-1:0]  scale_in,
    input  logic [dtzs_pkg::HI_W-1:0]            coef_hi_in,
    input  logic [dtzs_pkg::LO_W-1:0]            coef_lo_in,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [dtzs_pkg::ERR_W-1:0]           error_code,
    input  logic                                 sign_out,
    input  logic signed [dtzs_pkg::SCALE_W-1:0]  scale_out,
    input  logic [dtzs_pkg::HI_W-1:0]            coef_hi_out,
    input  logic [dtzs_pkg::LO_W-1:0]            coef_lo_out
);
    import dtzs_pkg::*;

    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] MAX_INFLIGHT = 2'd2;

    logic                              in_xfer;
    logic                              out_xfer;
    logic                              out_stall;
    logic [ERR_W+SCALE_W+COEF_W:0]     out_word;
    logic [CNT_W-1:0]                  inflight_reg;
    logic [CNT_W-1:0]                  inflight_next;

    always_comb
    begin
        in_xfer   = in_valid && in_ready;
        out_xfer  = out_valid && out_ready;
        out_stall = out_valid && !out_ready;
        out_word  = {error_code, sign_out, scale_out, coef_hi_out, coef_lo_out};
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `DTZS_ASSERT_NXT(a_one_at_a_time, in_xfer, !in_ready, "input taken while a value is in work")
    `DTZS_ASSERT_IMP(a_no_phantom, out_valid, inflight_reg != '0, "result without an input")
    `DTZS_ASSERT_IMP(a_full_blocks, inflight_reg == MAX_INFLIGHT, !in_ready, "too many in flight")
    `DTZS_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind decimal_trailing_zero_strip dtzs_checker u_dtzs_checker (.*);

### verif/tb_decimal_trailing_zero_strip.sv
// self-checking testbench for decimal_trailing_zero_strip
// needs dtzs_pkg and the rtl of the block; predicts every result and checks it per field
module tb_decimal_trailing_zero_strip;
    timeunit 1ns;
    timeprecision 1ps;

    import dtzs_pkg::*;

    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    localparam int CALM_TAIL = 150;
    localparam int HOLD_AT = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1130;

    typedef struct {
        class_t              cls;
        logic                sign;
        logic [SCALE_W-1:0]  scale;
        logic [COEF_W-1:0]   coef;
    } dec_value_t;

    typedef struct {
        err_t                err;
        logic                sign;
        logic [SCALE_W-1:0]  scale;
        logic [COEF_W-1:0]   coef;
    } dec_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CLASS_W-1:0]  value_class = '0;
    logic                sign_in = 1'b0;
    logic [SCALE_W-1:0]  scale_in = '0;
    logic [HI_W-1:0]     coef_hi_in = '0;
    logic [LO_W-1:0]     coef_lo_in = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ERR_W-1:0]    error_code;
    logic                sign_out;
    logic [SCALE_W-1:0]  scale_out;
    logic [HI_W-1:0]     coef_hi_out;
    logic [LO_W-1:0]     coef_lo_out;

    dec_value_t   stim_q[$];
    dec_result_t  reduced_q[$];
    dec_value_t   cur_value;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           results_seen = 0;
    int           total_items = 0;
    int           mismatch_count = 0;
    logic         hold_req = 1'b0;
    logic         hold_done = 1'b0;
    int           hold_left = 0;
    int           hold_seen = 0;

    decimal_trailing_zero_strip dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value_class (value_class),
        .sign_in     (sign_in),
        .scale_in    (scale_in),
        .coef_hi_in  (coef_hi_in),
        .coef_lo_in  (coef_lo_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .error_code  (error_code),
        .sign_out    (sign_out),
        .scale_out   (scale_out),
        .coef_hi_out (coef_hi_out),
        .coef_lo_out (coef_lo_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic dec_result_t reduce_decimal(dec_value_t v);
        dec_result_t r;
        int sc;
        int steps;
        r.err = ERR_OK;
        r.sign = v.sign;
        r.scale = v.scale;
        r.coef = v.coef;
        sc = int'($signed(v.scale));
        steps = 0;
        case (v.cls)
            CLS_NAN: r.err = ERR_NAN;
            CLS_INF: r.err = ERR_INF;
            CLS_FINITE:
            begin
                if (v.coef == '0)
                begin
                    r.sign = 1'b0;
                    r.scale = '0;
                end
                else
                begin
                    while (steps < STEP_LIMIT && sc < 0 && (r.coef % 10) == 0)
                    begin
                        r.coef = r.coef / 10;
                        sc++;
                        steps++;
                    end
                    r.scale = SCALE_W'(sc);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] pow10(int k);
        logic [COEF_W-1:0] p;
        p = COEF_W'(1);
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        return COEF_W'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic dec_value_t make_value(class_t c, logic s, int sc,
                                              logic [COEF_W-1:0] coef);
        dec_value_t v;
        v.cls = c;
        v.sign = s;
        v.scale = SCALE_W'(sc);
        v.coef = coef;
        return v;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // driver: a pending value stays on the port until its transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        dec_value_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                reduced_q.push_back(reduce_decimal(cur_value));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (stim_q.size() > 0)
            begin
                nxt = stim_q.pop_front();
                cur_value <= nxt;
                value_class <= nxt.cls;
                sign_in <= nxt.sign;
                scale_in <= nxt.scale;
                coef_hi_in <= nxt.coef[COEF_W-1:LO_W];
                coef_lo_in <= nxt.coef[LO_W-1:0];
                in_valid <= 1'b1;
                if (stim_q.size() > CALM_TAIL && (stim_q.size() / 128) % 3 != 0
                    && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        dec_result_t want;
        logic [COEF_W-1:0] got_coef;
        logic rdy;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (reduced_q.size() == 0)
                    flag_mismatch("result with no prediction waiting");
                else
                begin
                    want = reduced_q.pop_front();
                    got_coef = {coef_hi_out, coef_lo_out};
                    if (error_code !== want.err)
                        flag_mismatch($sformatf("error_code got %0d want %0d",
                                                error_code, want.err));
                    if (sign_out !== want.sign)
                        flag_mismatch($sformatf("sign_out got %0d want %0d",
                                                sign_out, want.sign));
                    if (scale_out !== want.scale)
                        flag_mismatch($sformatf("scale_out got %0d want %0d",
                                                $signed(scale_out), $signed(want.scale)));
                    if (got_coef !== want.coef)
                        flag_mismatch($sformatf("coef got %h want %h", got_coef, want.coef));
                end
            end
            rdy = 1'b1;
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rdy = 1'b0;
            end
            else if (results_seen < total_items - CALM_TAIL && (results_seen / 100) % 3 != 1
                     && $urandom_range(0, 7) == 0)
                recv_gap <= $urandom_range(1, 7);
            out_ready <= rdy && !hold_req;
        end
    end

    // one long receiver hold-off so the unit fills up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_req <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                hold_seen <= hold_seen + 1;
            if (hold_req)
            begin
                if (hold_left == 0)
                    hold_req <= 1'b0;
                else
                    hold_left <= hold_left - 1;
            end
            else if (!hold_done && hold_seen == HOLD_AT)
            begin
                hold_req <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    initial
    begin : stim_proc
        int k;
        int sc;
        int pick;
        logic [COEF_W-1:0] p;
        logic [COEF_W-1:0] m;
        class_t c;

        // directed values
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, -40, pow10(34)));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, -10, pow10(34)));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, -8192, COEF_MAX));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, -1, 1));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, 0, 100));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, 8191, 1000));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, -5, 0));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, 8191, 0));
        stim_q.push_back(make_value(CLS_ZERO, 1'b1, -8192, COEF_MAX));
        stim_q.push_back(make_value(CLS_ZERO, 1'b0, 0, 0));
        stim_q.push_back(make_value(CLS_INF, 1'b0, 0, 0));
        stim_q.push_back(make_value(CLS_INF, 1'b1, -8192, COEF_MAX));
        stim_q.push_back(make_value(CLS_NAN, 1'b1, -30, pow10(20)));
        stim_q.push_back(make_value(CLS_NAN, 1'b0, 8191, 0));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, -3, 120));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, -34, 7 * pow10(33)));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, -8192, pow10(33)));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, -1, 10));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, 0, COEF_MAX));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, -20, {{(HI_W-1){1'b0}}, 1'b1,
                                                            {LO_W{1'b0}}}));
        stim_q.push_back(make_value(CLS_FINITE, 1'b1, -19, pow10(19)));
        stim_q.push_back(make_value(CLS_FINITE, 1'b0, 5, pow10(30)));

        // random values, mostly finite with at least a known number of trailing zeros
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, 34);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: sc = 0 - int'($urandom_range(0, 40));
                4, 5: sc = int'($urandom_range(0, 2)) - 1 - k;
                6, 7: sc = int'($urandom_range(0, 16383)) - 8192;
                8: sc = int'($urandom_range(1, 8191));
                default: sc = 0;
            endcase
            if (pick < 72)
            begin
                p = pow10(k);
                if ($urandom_range(0, 2) == 0)
                    m = COEF_W'($urandom_range(1, 999));
                else if (k == 0)
                    m = rand_coef();
                else
                    m = rand_coef() % (COEF_MAX / p + 1);
                stim_q.push_back(make_value(CLS_FINITE, 1'($urandom_range(0, 1)), sc,
                                            m * p));
            end
            else if (pick < 77)
                stim_q.push_back(make_value(CLS_FINITE, 1'($urandom_range(0, 1)), sc,
                                            rand_coef()));
            else if (pick < 80)
                stim_q.push_back(make_value(CLS_FINITE, 1'($urandom_range(0, 1)), sc, 0));
            else
            begin
                if (pick < 88)
                    c = CLS_ZERO;
                else if (pick < 94)
                    c = CLS_INF;
                else
                    c = CLS_NAN;
                m = ($urandom_range(0, 1) == 0) ? '0 : rand_coef();
                stim_q.push_back(make_value(c, 1'($urandom_range(0, 1)), sc, m));
            end
        end
        total_items = stim_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() > 0 || in_valid)
            @(posedge clk);
        while (reduced_q.size() > 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
        if (mismatch_count == 0 && reduced_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
